/* hw/rtl/bcs_pkg.sv */
// ============================================================================
// Bit count and scan unit package
// Shared constants, operation codes and the stage records of the pipeline.
// ============================================================================
`default_nettype none

package bcs_pkg;

   localparam int DATA_W    = 64;
   localparam int CMD_W     = 4;
   localparam int SIZE_W    = 2;
   localparam int COUNT_W   = 7;
   localparam int NUM_BYTES = 8;
   localparam int NIBBLE_W  = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LZ       = 4'd0,
      CMD_LO       = 4'd1,
      CMD_TZ       = 4'd2,
      CMD_TO       = 4'd3,
      CMD_FLZ      = 4'd4,
      CMD_FLO      = 4'd5,
      CMD_FTZ      = 4'd6,
      CMD_FTO      = 4'd7,
      CMD_CNT_ZERO = 4'd8,
      CMD_CNT_ONE  = 4'd9,
      CMD_SINGLE   = 4'd10,
      CMD_WIDTH    = 4'd11,
      CMD_FLOOR    = 4'd12,
      CMD_CEIL     = 4'd13
   } cmd_type;

   // Output of the preparation stage: the word whose trailing zeros or
   // ones are to be counted, plus what the final stage needs.
   typedef struct packed {
      cmd_type             cmd;
      logic [COUNT_W-1:0]  width;
      logic                le_one;
      logic [DATA_W-1:0]   scan;
   } prep_type;

   // Per-byte partial counts.
   typedef struct packed {
      cmd_type                            cmd;
      logic [COUNT_W-1:0]                 width;
      logic                               le_one;
      logic [NUM_BYTES-1:0][NIBBLE_W-1:0] tz;
      logic [NUM_BYTES-1:0][NIBBLE_W-1:0] pop;
   } byte_type;

   // Merged count of the whole word.
   typedef struct packed {
      cmd_type             cmd;
      logic [COUNT_W-1:0]  width;
      logic                le_one;
      logic [COUNT_W-1:0]  count;
   } merge_type;

endpackage

`default_nettype wire

/* hw/rtl/bcs_if.sv */
// ============================================================================
// Bit count and scan unit channels
// Request and response channels with valid/ready handshakes.
// ============================================================================
`default_nettype none

interface bcs_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcs_pkg::CMD_W-1:0]     cmd;
   logic [bcs_pkg::SIZE_W-1:0]    operand_size;
   logic [bcs_pkg::DATA_W-1:0]    operand;

   modport source (output valid, output cmd, output operand_size, output operand,
                   input ready);
   modport sink   (input valid, input cmd, input operand_size, input operand,
                   output ready);
endinterface

interface bcs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcs_pkg::DATA_W-1:0]    answer;

   modport source (output valid, output answer, input ready);
   modport sink   (input valid, input answer, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bit_count_scan_unit.sv */
// ============================================================================
// Bit count and scan unit
// Leading/trailing counts, first positions, population counts, single-bit
// test, bit width, bit floor and bit ceiling at 8, 16, 32 or 64 bits.
// ============================================================================
//
//   Channel   Direction   Payload                               Handshake
//   req       in          cmd[3:0], operand_size[1:0],          valid/ready
//                         operand[63:0]
//   rsp       out         answer[63:0]                          valid/ready
//
// The unit takes one beat per cycle unless a stalled response backs up the
// pipeline, and returns its answer through the four register stages
// (prepare, per-byte count, merge, format).
// Reset clears only the stage valid bits; the unit keeps no other state.
// Each stage moves on when its successor has room, so a stalled response
// holds only as many stages as are full and bubbles fill up behind it.
//
`default_nettype none

module bit_count_scan_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   bcs_req_if.sink     req,
   bcs_rsp_if.source   rsp
);

   // Stage one turns every operation into a trailing-run count or a
   // population count of one 64-bit scan word.
   logic                 prep_valid;
   logic                 prep_ready;
   bcs_pkg::prep_type    prep_data;

   // Stage two counts inside each byte.
   logic                 byte_valid;
   logic                 byte_ready;
   bcs_pkg::byte_type    byte_data;

   // Stage three merges the eight byte results.
   logic                 merge_valid;
   logic                 merge_ready;
   bcs_pkg::merge_type   merge_data;

   bcs_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_cmd     (req.cmd),
      .in_size    (req.operand_size),
      .in_operand (req.operand),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_data   (prep_data)
   );

   bcs_byte_count u_byte_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (byte_valid),
      .out_ready (byte_ready),
      .out_data  (byte_data)
   );

   bcs_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (byte_valid),
      .in_ready  (byte_ready),
      .in_data   (byte_data),
      .out_valid (merge_valid),
      .out_ready (merge_ready),
      .out_data  (merge_data)
   );

   // The format stage's register is the response register itself.
   bcs_format u_format (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (merge_valid),
      .in_ready   (merge_ready),
      .in_data    (merge_data),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_answer (rsp.answer)
   );

endmodule

`default_nettype wire

/* hw/rtl/bcs_prep.sv */
// ============================================================================
// Bit count and scan unit, preparation stage
// Masks the operand, builds the word for the trailing-run or population count.
// ============================================================================
`default_nettype none

module bcs_prep (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [bcs_pkg::CMD_W-1:0]     in_cmd,
   input  wire logic [bcs_pkg::SIZE_W-1:0]    in_size,
   input  wire logic [bcs_pkg::DATA_W-1:0]    in_operand,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output bcs_pkg::prep_type                  out_data
);

   logic                           valid_ff;
   bcs_pkg::prep_type              data_ff;
   bcs_pkg::prep_type              data_in;

   logic [bcs_pkg::DATA_W-1:0]     mask;
   logic [5:0]                     shamt;
   logic [bcs_pkg::DATA_W-1:0]     v;
   logic [bcs_pkg::DATA_W-1:0]     nv;
   logic [bcs_pkg::DATA_W-1:0]     vm1;
   logic [bcs_pkg::DATA_W-1:0]     src;
   logic [bcs_pkg::DATA_W-1:0]     aligned;
   logic                           lead;
   logic                           trail;
   bcs_pkg::cmd_type               cmd;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      unique case (in_size)
         2'd0:    begin mask = 64'h0000_0000_0000_00FF; shamt = 6'd56; end
         2'd1:    begin mask = 64'h0000_0000_0000_FFFF; shamt = 6'd48; end
         2'd2:    begin mask = 64'h0000_0000_FFFF_FFFF; shamt = 6'd32; end
         default: begin mask = 64'hFFFF_FFFF_FFFF_FFFF; shamt = 6'd0;  end
      endcase
   end

   assign cmd = bcs_pkg::cmd_type'(in_cmd);
   assign v   = in_operand & mask;
   assign nv  = ~in_operand & mask;
   assign vm1 = v - 64'd1;

   // Leading forms are counted as trailing runs of the bit-reversed,
   // left-aligned word; the fill ones stop the count at the operand width.
   always_comb begin
      lead  = 1'b0;
      trail = 1'b0;
      unique case (cmd) inside
         bcs_pkg::CMD_LZ, bcs_pkg::CMD_FLO, bcs_pkg::CMD_WIDTH,
         bcs_pkg::CMD_FLOOR: begin
            src  = v;
            lead = 1'b1;
         end
         bcs_pkg::CMD_LO, bcs_pkg::CMD_FLZ: begin
            src  = nv;
            lead = 1'b1;
         end
         bcs_pkg::CMD_CEIL: begin
            src  = vm1;
            lead = 1'b1;
         end
         bcs_pkg::CMD_TZ, bcs_pkg::CMD_FTO: begin
            src   = v;
            trail = 1'b1;
         end
         bcs_pkg::CMD_TO, bcs_pkg::CMD_FTZ: begin
            src   = nv;
            trail = 1'b1;
         end
         bcs_pkg::CMD_CNT_ZERO: begin
            src = nv;
         end
         default: begin
            src = v;
         end
      endcase
   end

   always_comb begin
      aligned = (src << shamt) | ~({bcs_pkg::DATA_W{1'b1}} << shamt);
      data_in.cmd    = cmd;
      data_in.width  = bcs_pkg::COUNT_W'(7'd8 << in_size);
      data_in.le_one = (v[bcs_pkg::DATA_W-1:1] == '0);
      if (lead) begin
         for (int i = 0; i < bcs_pkg::DATA_W; i++) begin
            data_in.scan[i] = aligned[bcs_pkg::DATA_W-1-i];
         end
      end else if (trail) begin
         data_in.scan = src | ~mask;
      end else begin
         data_in.scan = src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bcs_byte_count.sv */
// ============================================================================
// Bit count and scan unit, byte count stage
// Trailing-zero count and population count of each byte of the scan word.
// ============================================================================
`default_nettype none

module bcs_byte_count (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bcs_pkg::prep_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bcs_pkg::byte_type       out_data
);

   logic                 valid_ff;
   bcs_pkg::byte_type    data_ff;
   bcs_pkg::byte_type    data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.cmd    = in_data.cmd;
      data_in.width  = in_data.width;
      data_in.le_one = in_data.le_one;
      for (int b = 0; b < bcs_pkg::NUM_BYTES; b++) begin
         data_in.tz[b]  = 4'd8;
         data_in.pop[b] = 4'd0;
         for (int j = 7; j >= 0; j--) begin
            if (in_data.scan[8*b+j]) begin
               data_in.tz[b] = 4'(j);
            end
         end
         for (int j = 0; j < 8; j++) begin
            data_in.pop[b] = data_in.pop[b] + {3'd0, in_data.scan[8*b+j]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bcs_merge.sv */
// ============================================================================
// Bit count and scan unit, merge stage
// Combines the byte counts into one count of the whole word.
// ============================================================================
`default_nettype none

module bcs_merge (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bcs_pkg::byte_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bcs_pkg::merge_type      out_data
);

   logic                              valid_ff;
   bcs_pkg::merge_type                data_ff;
   bcs_pkg::merge_type                data_in;
   logic [bcs_pkg::COUNT_W-1:0]       tz_total;
   logic [bcs_pkg::COUNT_W-1:0]       pop_total;

   assign in_ready = !valid_ff || out_ready;

   // The lowest byte that holds a set bit fixes the trailing count.
   always_comb begin
      tz_total  = 7'd64;
      pop_total = '0;
      for (int b = bcs_pkg::NUM_BYTES - 1; b >= 0; b--) begin
         if (in_data.tz[b] != 4'd8) begin
            tz_total = {1'b0, 3'(b), in_data.tz[b][2:0]};
         end
      end
      for (int b = 0; b < bcs_pkg::NUM_BYTES; b++) begin
         pop_total = pop_total + {3'd0, in_data.pop[b]};
      end
   end

   always_comb begin
      data_in.cmd    = in_data.cmd;
      data_in.width  = in_data.width;
      data_in.le_one = in_data.le_one;
      case (in_data.cmd) inside
         bcs_pkg::CMD_CNT_ZERO, bcs_pkg::CMD_CNT_ONE, bcs_pkg::CMD_SINGLE: begin
            data_in.count = pop_total;
         end
         default: begin
            data_in.count = tz_total;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bcs_format.sv */
// ============================================================================
// Bit count and scan unit, format stage
// Turns the count into the answer of the operation and holds the response.
// ============================================================================
`default_nettype none

module bcs_format (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire bcs_pkg::merge_type          in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [bcs_pkg::DATA_W-1:0]       out_answer
);

   logic                              valid_ff;
   logic [bcs_pkg::DATA_W-1:0]        answer_ff;
   logic [bcs_pkg::DATA_W-1:0]        answer_in;
   logic [bcs_pkg::COUNT_W-1:0]       bw;
   logic [bcs_pkg::COUNT_W-1:0]       bw_less;
   logic [bcs_pkg::DATA_W-1:0]        count_ext;
   logic                              none_found;

   assign in_ready = !valid_ff || out_ready;

   assign bw         = in_data.width - in_data.count;
   assign bw_less    = bw - 7'd1;
   assign count_ext  = {{(bcs_pkg::DATA_W-bcs_pkg::COUNT_W){1'b0}}, in_data.count};
   assign none_found = (in_data.count == in_data.width);

   always_comb begin
      unique case (in_data.cmd) inside
         bcs_pkg::CMD_LZ, bcs_pkg::CMD_LO, bcs_pkg::CMD_TZ, bcs_pkg::CMD_TO,
         bcs_pkg::CMD_CNT_ZERO, bcs_pkg::CMD_CNT_ONE: begin
            answer_in = count_ext;
         end
         bcs_pkg::CMD_FLZ, bcs_pkg::CMD_FLO, bcs_pkg::CMD_FTZ, bcs_pkg::CMD_FTO: begin
            answer_in = none_found ? '0 : count_ext + 64'd1;
         end
         bcs_pkg::CMD_SINGLE: begin
            answer_in = {63'd0, (in_data.count == 7'd1)};
         end
         bcs_pkg::CMD_WIDTH: begin
            answer_in = {{(bcs_pkg::DATA_W-bcs_pkg::COUNT_W){1'b0}}, bw};
         end
         bcs_pkg::CMD_FLOOR: begin
            answer_in = (bw == '0) ? '0 : (64'd1 << bw_less[5:0]);
         end
         bcs_pkg::CMD_CEIL: begin
            if (in_data.le_one) begin
               answer_in = 64'd1;
            end else if (bw >= in_data.width) begin
               answer_in = '0;
            end else begin
               answer_in = 64'd1 << bw[5:0];
            end
         end
         default: begin
            answer_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         answer_ff <= answer_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_answer = answer_ff;

endmodule

`default_nettype wire
